// ----- hw/rtl/cpu_eu_pkg.sv -----
// Shared types and constants of the 6502 execute unit.
// Holds the operation codes, the register file and result structs.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package cpu_eu_pkg;

  localparam int KindW = 7;

  // Status bit positions, N V U B D I Z C from bit 7 down to bit 0.
  localparam int FlC = 0;
  localparam int FlZ = 1;
  localparam int FlI = 2;
  localparam int FlD = 3;
  localparam int FlB = 4;
  localparam int FlU = 5;
  localparam int FlV = 6;
  localparam int FlN = 7;

  localparam logic [7:0] StackReset = 8'hFD;
  localparam logic [7:0] FlagsReset = 8'h24;
  localparam logic [7:0] AneMagic   = 8'hEE;
  localparam logic [7:0] LxaMagic   = 8'hFF;

  typedef enum logic [KindW-1:0] {
    K_LDA = 7'd0,  K_STA = 7'd1,  K_LDX = 7'd2,  K_STX = 7'd3,  K_LDY = 7'd4,
    K_STY = 7'd5,  K_TAX = 7'd6,  K_TXA = 7'd7,  K_TAY = 7'd8,  K_TYA = 7'd9,
    K_TXS = 7'd10, K_TSX = 7'd11, K_ADC = 7'd12, K_SBC = 7'd13, K_INC = 7'd14,
    K_DEC = 7'd15, K_INX = 7'd16, K_DEX = 7'd17, K_INY = 7'd18, K_DEY = 7'd19,
    K_ASL = 7'd20, K_LSR = 7'd21, K_ROL = 7'd22, K_ROR = 7'd23, K_AND = 7'd24,
    K_ORA = 7'd25, K_EOR = 7'd26, K_BIT = 7'd27, K_CMP = 7'd28, K_CPX = 7'd29,
    K_CPY = 7'd30, K_BCC = 7'd31, K_BCS = 7'd32, K_BEQ = 7'd33, K_BNE = 7'd34,
    K_BPL = 7'd35, K_BMI = 7'd36, K_BVC = 7'd37, K_BVS = 7'd38, K_CLC = 7'd39,
    K_SEC = 7'd40, K_CLI = 7'd41, K_SEI = 7'd42, K_CLD = 7'd43, K_SED = 7'd44,
    K_CLV = 7'd45, K_NOP = 7'd46, K_SLO = 7'd47, K_RLA = 7'd48, K_SRE = 7'd49,
    K_RRA = 7'd50, K_SAX = 7'd51, K_LAX = 7'd52, K_DCP = 7'd53, K_ISC = 7'd54,
    K_SHA = 7'd55, K_SHS = 7'd56, K_SHY = 7'd57, K_SHX = 7'd58, K_LAS = 7'd59,
    K_ANC = 7'd60, K_ASR = 7'd61, K_ARR = 7'd62, K_ANE = 7'd63, K_LXA = 7'd64,
    K_AXS = 7'd65
  } kind_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] xreg;
    logic [7:0] yreg;
    logic [7:0] stack_ptr;
    logic [7:0] flags;
  } regs_t;

  typedef struct packed {
    logic [7:0] mem_value;
    logic [7:0] addr_hi_out;
    logic       branch_taken;
  } res_t;

endpackage

// ----- hw/rtl/cpu_eu_alu.sv -----
// Combinational execute logic: one 6502 operation on the register file.
// Uses cpu_eu_pkg for the operation codes and the register and result structs.
`timescale 1ns / 1ps

module cpu_eu_alu (
  input  cpu_eu_pkg::regs_t st,
  input  cpu_eu_pkg::kind_t kind,
  input  logic [7:0]        operand,
  input  logic [7:0]        addr_hi,
  input  logic              page_crossed,
  output cpu_eu_pkg::regs_t st_nxt,
  output cpu_eu_pkg::res_t  res
);

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] q;
    q = p;
    q[cpu_eu_pkg::FlZ] = (v == 8'd0);
    q[cpu_eu_pkg::FlN] = v[7];
    return q;
  endfunction

  logic [7:0] a, x, y, s, p, m, hi, t, mask, addend, add_r, m_inc, m_dec;
  logic [8:0] sum;
  logic       cin, add_cin, add_v, take;

  // One shared adder serves ADC, SBC, RRA and ISC.
  always_comb begin
    cin   = st.flags[cpu_eu_pkg::FlC];
    m_inc = operand + 8'd1;
    m_dec = operand - 8'd1;
    add_cin = cin;
    unique case (kind)
      cpu_eu_pkg::K_SBC: addend = ~operand;
      cpu_eu_pkg::K_ISC: addend = ~m_inc;
      cpu_eu_pkg::K_RRA: begin
        // The rotate's carry out feeds the add.
        addend  = {cin, operand[7:1]};
        add_cin = operand[0];
      end
      default: addend = operand;
    endcase
    sum   = {1'b0, st.acc} + {1'b0, addend} + {8'd0, add_cin};
    add_r = sum[7:0];
    add_v = ((add_r ^ st.acc) & (add_r ^ addend)) >> 7 != 8'd0;
  end

  always_comb begin
    a    = st.acc;
    x    = st.xreg;
    y    = st.yreg;
    s    = st.stack_ptr;
    p    = st.flags;
    m    = operand;
    hi   = addr_hi;
    take = 1'b0;
    t    = 8'd0;
    mask = page_crossed ? addr_hi : addr_hi + 8'd1;
    unique case (kind)
      cpu_eu_pkg::K_LDA: begin a = m; p = set_nz(p, a); end
      cpu_eu_pkg::K_STA: m = a;
      cpu_eu_pkg::K_LDX: begin x = m; p = set_nz(p, x); end
      cpu_eu_pkg::K_STX: m = x;
      cpu_eu_pkg::K_LDY: begin y = m; p = set_nz(p, y); end
      cpu_eu_pkg::K_STY: m = y;
      cpu_eu_pkg::K_TAX: begin x = a; p = set_nz(p, x); end
      cpu_eu_pkg::K_TXA: begin a = x; p = set_nz(p, a); end
      cpu_eu_pkg::K_TAY: begin y = a; p = set_nz(p, y); end
      cpu_eu_pkg::K_TYA: begin a = y; p = set_nz(p, a); end
      cpu_eu_pkg::K_TXS: s = x;
      cpu_eu_pkg::K_TSX: begin x = s; p = set_nz(p, x); end
      cpu_eu_pkg::K_ADC, cpu_eu_pkg::K_SBC: begin
        a = add_r;
        p[cpu_eu_pkg::FlC] = sum[8];
        p[cpu_eu_pkg::FlV] = add_v;
        p = set_nz(p, a);
      end
      cpu_eu_pkg::K_INC: begin m = m_inc; p = set_nz(p, m); end
      cpu_eu_pkg::K_DEC: begin m = m_dec; p = set_nz(p, m); end
      cpu_eu_pkg::K_INX: begin x = x + 8'd1; p = set_nz(p, x); end
      cpu_eu_pkg::K_DEX: begin x = x - 8'd1; p = set_nz(p, x); end
      cpu_eu_pkg::K_INY: begin y = y + 8'd1; p = set_nz(p, y); end
      cpu_eu_pkg::K_DEY: begin y = y - 8'd1; p = set_nz(p, y); end
      cpu_eu_pkg::K_ASL: begin
        p[cpu_eu_pkg::FlC] = m[7]; m = {m[6:0], 1'b0}; p = set_nz(p, m);
      end
      cpu_eu_pkg::K_LSR: begin
        p[cpu_eu_pkg::FlC] = m[0]; m = {1'b0, m[7:1]}; p = set_nz(p, m);
      end
      cpu_eu_pkg::K_ROL: begin
        p[cpu_eu_pkg::FlC] = m[7]; m = {m[6:0], cin}; p = set_nz(p, m);
      end
      cpu_eu_pkg::K_ROR: begin
        p[cpu_eu_pkg::FlC] = m[0]; m = {cin, m[7:1]}; p = set_nz(p, m);
      end
      cpu_eu_pkg::K_AND: begin a = a & m; p = set_nz(p, a); end
      cpu_eu_pkg::K_ORA: begin a = a | m; p = set_nz(p, a); end
      cpu_eu_pkg::K_EOR: begin a = a ^ m; p = set_nz(p, a); end
      cpu_eu_pkg::K_BIT: begin
        p[cpu_eu_pkg::FlV] = m[6];
        p[cpu_eu_pkg::FlN] = m[7];
        p[cpu_eu_pkg::FlZ] = ((m & a) == 8'd0);
      end
      cpu_eu_pkg::K_CMP: begin p[cpu_eu_pkg::FlC] = (a >= m); p = set_nz(p, a - m); end
      cpu_eu_pkg::K_CPX: begin p[cpu_eu_pkg::FlC] = (x >= m); p = set_nz(p, x - m); end
      cpu_eu_pkg::K_CPY: begin p[cpu_eu_pkg::FlC] = (y >= m); p = set_nz(p, y - m); end
      cpu_eu_pkg::K_BCC: take = ~p[cpu_eu_pkg::FlC];
      cpu_eu_pkg::K_BCS: take = p[cpu_eu_pkg::FlC];
      cpu_eu_pkg::K_BEQ: take = p[cpu_eu_pkg::FlZ];
      cpu_eu_pkg::K_BNE: take = ~p[cpu_eu_pkg::FlZ];
      cpu_eu_pkg::K_BPL: take = ~p[cpu_eu_pkg::FlN];
      cpu_eu_pkg::K_BMI: take = p[cpu_eu_pkg::FlN];
      cpu_eu_pkg::K_BVC: take = ~p[cpu_eu_pkg::FlV];
      cpu_eu_pkg::K_BVS: take = p[cpu_eu_pkg::FlV];
      cpu_eu_pkg::K_CLC: p[cpu_eu_pkg::FlC] = 1'b0;
      cpu_eu_pkg::K_SEC: p[cpu_eu_pkg::FlC] = 1'b1;
      cpu_eu_pkg::K_CLI: p[cpu_eu_pkg::FlI] = 1'b0;
      cpu_eu_pkg::K_SEI: p[cpu_eu_pkg::FlI] = 1'b1;
      cpu_eu_pkg::K_CLD: p[cpu_eu_pkg::FlD] = 1'b0;
      cpu_eu_pkg::K_SED: p[cpu_eu_pkg::FlD] = 1'b1;
      cpu_eu_pkg::K_CLV: p[cpu_eu_pkg::FlV] = 1'b0;
      cpu_eu_pkg::K_SLO: begin
        p[cpu_eu_pkg::FlC] = m[7]; m = {m[6:0], 1'b0};
        a = a | m; p = set_nz(p, a);
      end
      cpu_eu_pkg::K_RLA: begin
        p[cpu_eu_pkg::FlC] = m[7]; m = {m[6:0], cin};
        a = a & m; p = set_nz(p, a);
      end
      cpu_eu_pkg::K_SRE: begin
        p[cpu_eu_pkg::FlC] = m[0]; m = {1'b0, m[7:1]};
        a = a ^ m; p = set_nz(p, a);
      end
      cpu_eu_pkg::K_RRA: begin
        m = {cin, m[7:1]};
        a = add_r;
        p[cpu_eu_pkg::FlC] = sum[8];
        p[cpu_eu_pkg::FlV] = add_v;
        p = set_nz(p, a);
      end
      cpu_eu_pkg::K_SAX: m = a & x;
      cpu_eu_pkg::K_LAX: begin a = m; x = m; p = set_nz(p, a); end
      cpu_eu_pkg::K_DCP: begin
        m = m_dec;
        p[cpu_eu_pkg::FlC] = (a >= m);
        p = set_nz(p, a - m);
      end
      cpu_eu_pkg::K_ISC: begin
        m = m_inc;
        a = add_r;
        p[cpu_eu_pkg::FlC] = sum[8];
        p[cpu_eu_pkg::FlV] = add_v;
        p = set_nz(p, a);
      end
      cpu_eu_pkg::K_SHA, cpu_eu_pkg::K_SHS: begin
        if (kind == cpu_eu_pkg::K_SHS) begin
          s = a & x;
        end
        m = a & x & mask;
        if (page_crossed) begin
          hi = m;
        end
      end
      cpu_eu_pkg::K_SHY: begin
        m = y & mask;
        if (page_crossed) begin
          hi = m;
        end
      end
      cpu_eu_pkg::K_SHX: begin
        m = x & mask;
        if (page_crossed) begin
          hi = m;
        end
      end
      cpu_eu_pkg::K_LAS: begin
        t = m & s; a = t; x = t; s = t; p = set_nz(p, t);
      end
      cpu_eu_pkg::K_ANC: begin
        a = a & m; p[cpu_eu_pkg::FlC] = a[7]; p = set_nz(p, a);
      end
      cpu_eu_pkg::K_ASR: begin
        t = a & m; p[cpu_eu_pkg::FlC] = t[0]; a = {1'b0, t[7:1]}; p = set_nz(p, a);
      end
      cpu_eu_pkg::K_ARR: begin
        t = a & m;
        a = {cin, t[7:1]};
        p[cpu_eu_pkg::FlC] = a[6];
        p[cpu_eu_pkg::FlV] = a[6] ^ a[5];
        p = set_nz(p, a);
      end
      cpu_eu_pkg::K_ANE: begin
        a = (a | cpu_eu_pkg::AneMagic) & x & m; p = set_nz(p, a);
      end
      cpu_eu_pkg::K_LXA: begin
        a = (a | cpu_eu_pkg::LxaMagic) & m; x = a; p = set_nz(p, a);
      end
      cpu_eu_pkg::K_AXS: begin
        t = a & x;
        p[cpu_eu_pkg::FlC] = (t >= m);
        x = t - m;
        p = set_nz(p, x);
      end
      // NOP and the codes above the last operation leave everything as it is.
      default: ;
    endcase
  end

  assign st_nxt.acc       = a;
  assign st_nxt.xreg      = x;
  assign st_nxt.yreg      = y;
  assign st_nxt.stack_ptr = s;
  assign st_nxt.flags     = p;
  assign res.mem_value    = m;
  assign res.addr_hi_out  = hi;
  assign res.branch_taken = take;

endmodule

// ----- hw/rtl/cpu6502_execute_unit.sv -----
// Top level of the 6502 execute unit: register file, stream ports and
// output skid stage. Depends on cpu_eu_pkg and cpu_eu_alu.
`timescale 1ns / 1ps

// The unit takes one operation per clock cycle and returns one registered result
// item per operation. The work is a single
// pass through the execute logic from the kept A, X, Y, S and P registers,
// which are updated at the same edge, so dependent operations may follow each
// other in consecutive cycles. A two-entry output stage lets the input keep
// accepting while one result waits; the input stalls only when both entries
// are full. Decimal mode is not applied to arithmetic.
module cpu6502_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // operand[7:0], addr_hi[15:8], page_crossed[16], zero[23:17]
  input  logic [23:0] in_tdata,
  // kind[6:0]
  input  logic [6:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // mem_value[7:0], addr_hi_out[15:8], branch_taken[16], acc_out[24:17],
  // xreg_out[32:25], yreg_out[40:33], stack_out[48:41], flags_out[56:49], zero[63:57]
  output logic [63:0] out_tdata
);

  cpu_eu_pkg::regs_t st_r, st_nxt;
  cpu_eu_pkg::res_t  res;
  logic [63:0]       item_nxt, out_data_r, skid_data_r;
  logic              out_valid_r, skid_valid_r, in_fire, out_free;

  cpu_eu_alu u_alu (
    .st           (st_r),
    .kind         (cpu_eu_pkg::kind_t'(in_tuser)),
    .operand      (in_tdata[7:0]),
    .addr_hi      (in_tdata[15:8]),
    .page_crossed (in_tdata[16]),
    .st_nxt       (st_nxt),
    .res          (res)
  );

  assign in_tready = ~skid_valid_r;
  assign in_fire   = in_tvalid & in_tready;
  assign out_free  = ~out_valid_r | out_tready;

  assign item_nxt = {7'd0, st_nxt.flags, st_nxt.stack_ptr, st_nxt.yreg, st_nxt.xreg,
                     st_nxt.acc, res.branch_taken, res.addr_hi_out, res.mem_value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.acc       <= 8'd0;
      st_r.xreg      <= 8'd0;
      st_r.yreg      <= 8'd0;
      st_r.stack_ptr <= cpu_eu_pkg::StackReset;
      st_r.flags     <= cpu_eu_pkg::FlagsReset;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
      end
      if (out_free) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_fire;
        end
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_fire) begin
        out_data_r <= item_nxt;
      end
    end else if (in_fire) begin
      skid_data_r <= item_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The skid entry only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds an item while the output register is empty");

  // A result taken while the skid entry is full is replaced at once.
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_tready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry was not moved to the output register");

  // No operation touches the U and B bits of the kept status byte.
  a_fixed_flags: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.flags[cpu_eu_pkg::FlU] && !st_r.flags[cpu_eu_pkg::FlB])
    else $error("U or B bit of the status register changed");

  // Every accepted item leaves the output register valid in the next cycle.
  a_item_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule
